@@ src/page_table_mirror_mapper_defines.svh @@
// ----------------------------------------------------------------------------
// page_table_mirror_mapper_defines
// Assertion macros shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef PAGE_TABLE_MIRROR_MAPPER_DEFINES_SVH
`define PAGE_TABLE_MIRROR_MAPPER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PTMM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PTMM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/ptmm_pkg.sv @@
// ----------------------------------------------------------------------------
// ptmm_pkg
// Word types and command codes of the page table mirror mapper.
// ----------------------------------------------------------------------------
package ptmm_pkg;

	localparam logic [1:0] CMD_MOUNT  = 2'd0;
	localparam logic [1:0] CMD_MIRROR = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	localparam int unsigned REGION_COUNT = 128;
	localparam int unsigned HANDLE_W     = 7;
	localparam int unsigned STATIC_BIT   = 7;
	localparam int unsigned ENTRY_W      = 32;

	typedef struct packed {
		logic [1:0]          command;
		logic [31:0]         address;
		logic [31:0]         address_mask;
		logic [31:0]         base_offset;
		logic [31:0]         size_bytes;
		logic [31:0]         source_address;
		logic [HANDLE_W-1:0] region_handle;
		logic                region_dynamic;
	} in_word_t;

	typedef struct packed {
		logic                entry_mapped;
		logic                is_static;
		logic [HANDLE_W-1:0] region_index;
		logic [31:0]         mapped_offset;
		logic                align_error;
	} out_word_t;

endpackage

@@ src/page_table_mirror_mapper.sv @@
// ----------------------------------------------------------------------------
// page_table_mirror_mapper
// Page table over the 32-bit address space with mirrored mounts, range
// copies and lookups; result word held in an output register.
//
//   channel | valid     | ready     | word
//   --------+-----------+-----------+----------
//   command | cmd_valid | cmd_ready | cmd_word
//   result  | res_valid | res_ready | res_word
//
// After reset the table is cleared one entry a cycle, all 2^(32-PAGE_BITS)
// entries (65536 by default); cmd_ready stays low until then.
// Lookup: one RAM read. Mount: one entry written per cycle, pages * mirrors
// entries in all. Mirror: read then write per page on the single RAM.
// Rejected or empty commands write no entry.
// A stalled result holds the register; one further word is finished and
// waits in the sequencer until the register frees.
// ----------------------------------------------------------------------------
module page_table_mirror_mapper #(
	parameter int PAGE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ptmm_pkg::in_word_t  cmd_word,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	output ptmm_pkg::out_word_t res_word,
	output logic                res_valid,
	input  logic                res_ready
);
	import ptmm_pkg::*;

	out_word_t rsp_word;
	logic      rsp_valid;
	logic      rsp_take;
	out_word_t res_q;
	logic      res_valid_q;

	assign rsp_take = !res_valid_q || res_ready;

	ptmm_seq #(
		.PAGE_BITS(PAGE_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_word (cmd_word),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.rsp_word (rsp_word),
		.rsp_valid(rsp_valid),
		.rsp_take (rsp_take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rsp_take) begin
			res_valid_q <= rsp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_take && rsp_valid) begin
			res_q <= rsp_word;
		end
	end

	assign res_word  = res_q;
	assign res_valid = res_valid_q;
endmodule

@@ src/ptmm_ram.sv @@
// ----------------------------------------------------------------------------
// ptmm_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ptmm_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH  = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);
	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ src/ptmm_seq.sv @@
// ----------------------------------------------------------------------------
// ptmm_seq
// Command sequencer: table clear, lookup, mount and mirror walks over the
// page table RAM.
// ----------------------------------------------------------------------------
module ptmm_seq #(
	parameter int PAGE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ptmm_pkg::in_word_t   cmd_word,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	output ptmm_pkg::out_word_t  rsp_word,
	output logic                 rsp_valid,
	input  logic                 rsp_take
);
	import ptmm_pkg::*;

	localparam int PIW   = 32 - PAGE_BITS;
	localparam int DEPTH = 2 ** PIW;

	localparam logic [2:0] S_CLEAR   = 3'd0;
	localparam logic [2:0] S_IDLE    = 3'd1;
	localparam logic [2:0] S_LOOKUP  = 3'd2;
	localparam logic [2:0] S_MOUNT   = 3'd3;
	localparam logic [2:0] S_COPY_RD = 3'd4;
	localparam logic [2:0] S_COPY_WR = 3'd5;
	localparam logic [2:0] S_DONE    = 3'd6;

	logic [2:0]           state_q;
	logic [PIW-1:0]       pc_q;
	logic [PIW-1:0]       last_q;
	logic [PIW-1:0]       sel_q;
	logic [PIW-1:0]       inv_q;
	logic [PIW-1:0]       base_q;
	logic [PIW-1:0]       src_q;
	logic [HANDLE_W-1:0]  handle_q;
	logic                 stat_q;
	logic                 err_q;
	logic [PAGE_BITS-1:0] lk_off_q;

	logic                 acc;
	logic [31:0]          start;
	logic [PIW-1:0]       npages;
	logic [PIW-1:0]       mask_p;
	logic                 start_mis;
	logic                 size_mis;
	logic                 mask_mis;
	logic                 src_mis;
	logic                 handle_ok;
	logic [PIW-1:0]       dst;
	logic [PIW-1:0]       sel_nx;
	logic                 page_end;
	logic                 last_mirror;
	logic [ENTRY_W-1:0]   mount_ent;

	logic                 we;
	logic [PIW-1:0]       waddr;
	logic [ENTRY_W-1:0]   wdata;
	logic                 re;
	logic [PIW-1:0]       raddr;
	logic [ENTRY_W-1:0]   rdata;

	assign cmd_ready = (state_q == S_IDLE);
	assign acc       = cmd_valid && cmd_ready;

	assign start     = cmd_word.address + cmd_word.base_offset;
	assign npages    = cmd_word.size_bytes[31:PAGE_BITS];
	assign mask_p    = cmd_word.address_mask[31:PAGE_BITS];
	assign start_mis = |start[PAGE_BITS-1:0];
	assign size_mis  = |cmd_word.size_bytes[PAGE_BITS-1:0];
	assign mask_mis  = ~&cmd_word.address_mask[PAGE_BITS-1:0];
	assign src_mis   = |cmd_word.source_address[PAGE_BITS-1:0];
	assign handle_ok = 9'(cmd_word.region_handle) < 9'(REGION_COUNT);

	assign dst         = (base_q | sel_q) + pc_q;
	assign sel_nx      = ((sel_q | ~inv_q) + PIW'(1)) & inv_q;
	assign page_end    = (pc_q == last_q);
	assign last_mirror = (sel_q == inv_q);

	always_comb begin
		mount_ent                  = '0;
		mount_ent[31:PAGE_BITS]    = pc_q;
		mount_ent[STATIC_BIT]      = stat_q;
		mount_ent[HANDLE_W-1:0]    = handle_q;
	end

	// RAM port muxing
	always_comb begin
		we    = (state_q == S_CLEAR) || (state_q == S_MOUNT) || (state_q == S_COPY_WR);
		waddr = (state_q == S_CLEAR) ? pc_q : dst;
		case (state_q)
			S_MOUNT:   wdata = mount_ent;
			S_COPY_WR: wdata = rdata;
			default:   wdata = '0;
		endcase
		re    = (state_q == S_COPY_RD) || (acc && (cmd_word.command == CMD_LOOKUP));
		raddr = (state_q == S_COPY_RD) ? (src_q + pc_q) : cmd_word.address[31:PAGE_BITS];
	end

	ptmm_ram #(
		.DATA_W(ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		rsp_word = '0;
		if (state_q == S_LOOKUP) begin
			rsp_word.entry_mapped  = |rdata;
			rsp_word.is_static     = rdata[STATIC_BIT];
			rsp_word.region_index  = rdata[HANDLE_W-1:0];
			rsp_word.mapped_offset = {rdata[31:PAGE_BITS], lk_off_q};
		end else begin
			rsp_word.align_error   = err_q;
		end
	end
	assign rsp_valid = (state_q == S_LOOKUP) || (state_q == S_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			pc_q    <= '0;
			last_q  <= '0;
			sel_q   <= '0;
			inv_q   <= '0;
			err_q   <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					pc_q <= pc_q + PIW'(1);
					if (&pc_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc) begin
						pc_q   <= '0;
						sel_q  <= '0;
						last_q <= npages - PIW'(1);
						err_q  <= 1'b0;
						case (cmd_word.command)
							CMD_MOUNT: begin
								inv_q <= ~mask_p;
								if (start_mis || size_mis || mask_mis) begin
									err_q   <= 1'b1;
									state_q <= S_DONE;
								end else if (handle_ok && (npages != '0)) begin
									state_q <= S_MOUNT;
								end else begin
									state_q <= S_DONE;
								end
							end
							CMD_MIRROR: begin
								inv_q <= '0;
								if (start_mis || size_mis || src_mis) begin
									err_q   <= 1'b1;
									state_q <= S_DONE;
								end else if (npages != '0) begin
									state_q <= S_COPY_RD;
								end else begin
									state_q <= S_DONE;
								end
							end
							CMD_LOOKUP: begin
								state_q <= S_LOOKUP;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_MOUNT, S_COPY_WR: begin
					if (!page_end) begin
						pc_q <= pc_q + PIW'(1);
					end else begin
						pc_q  <= '0;
						sel_q <= sel_nx;
					end
					if (page_end && last_mirror) begin
						state_q <= S_DONE;
					end else if (state_q == S_COPY_WR) begin
						state_q <= S_COPY_RD;
					end
				end
				S_COPY_RD: begin
					state_q <= S_COPY_WR;
				end
				S_LOOKUP, S_DONE: begin
					if (rsp_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// walk payload, loaded on accept
	always_ff @(posedge clk) begin
		if (acc) begin
			base_q   <= (cmd_word.command == CMD_MIRROR) ? start[31:PAGE_BITS]
			                                             : (start[31:PAGE_BITS] & mask_p);
			src_q    <= cmd_word.source_address[31:PAGE_BITS];
			handle_q <= cmd_word.region_handle;
			stat_q   <= ~cmd_word.region_dynamic;
			lk_off_q <= cmd_word.address[PAGE_BITS-1:0];
		end
	end
endmodule

@@ src/ptmm_checker.sv @@
// ----------------------------------------------------------------------------
// ptmm_checker
// Port-level checks of the page table mirror mapper, bound to the top level.
// ----------------------------------------------------------------------------
`include "page_table_mirror_mapper_defines.svh"

module ptmm_port_checker (
	input logic                clk,
	input logic                arst_n,
	input ptmm_pkg::in_word_t  cmd_word,
	input logic                cmd_valid,
	input logic                cmd_ready,
	input ptmm_pkg::out_word_t res_word,
	input logic                res_valid,
	input logic                res_ready
);
	import ptmm_pkg::*;

	logic res_stall;
	logic cmd_acc;
	logic res_err;
	logic res_unmapped;
	logic lookup_zero;
	logic entry_zero;

	assign res_stall    = res_valid && !res_ready;
	assign cmd_acc      = cmd_valid && cmd_ready;
	assign res_err      = res_valid && res_word.align_error;
	assign res_unmapped = res_valid && !res_word.entry_mapped;
	assign lookup_zero  = !res_word.entry_mapped && !res_word.is_static
		&& (res_word.region_index == '0) && (res_word.mapped_offset == '0);
	assign entry_zero   = !res_word.is_static && (res_word.region_index == '0);

	`PTMM_ASSERT_NEXT(a_res_hold, res_stall, res_valid && $stable(res_word), "result changed in stall")
	`PTMM_ASSERT_NEXT(a_busy_after_accept, cmd_acc, !cmd_ready, "command accepted back to back")
	`PTMM_ASSERT_SAME(a_err_clean, res_err, lookup_zero, "align error with lookup fields set")
	`PTMM_ASSERT_SAME(a_unmapped_clean, res_unmapped, entry_zero, "unmapped word with entry fields")
endmodule

bind page_table_mirror_mapper ptmm_port_checker u_ptmm_checker (.*);

@@ bench/ptmm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptmm_checker
// Watches both channels of the page table mirror mapper. Every accepted
// command word is run through a local copy of the page table to work out its
// result word; every accepted result word is compared field by field with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ptmm_checker #(
	parameter int PAGE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ptmm_pkg::in_word_t  cmd_word,
	input  logic                cmd_valid,
	input  logic                cmd_ready,
	input  ptmm_pkg::out_word_t res_word,
	input  logic                res_valid,
	input  logic                res_ready,
	output int unsigned         fail_count,
	output int unsigned         pending,
	output int unsigned         lookup_count,
	output int unsigned         hit_count,
	output int unsigned         reject_count
);
	import ptmm_pkg::*;

	localparam int unsigned PAGE_COUNT  = 1 << (32 - PAGE_BITS);
	localparam logic [31:0] INDEX_MASK  = PAGE_COUNT - 1;
	localparam logic [31:0] OFFSET_MASK = (32'd1 << PAGE_BITS) - 32'd1;
	localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

	logic [31:0] page_image [PAGE_COUNT];
	out_word_t   result_q [$];

	// walk every mirror of start under mask; copy mode reads from src_page
	function automatic void write_mirrors(logic [31:0] start, logic [31:0] mask,
			logic [31:0] npages, logic [31:0] src_page, logic copy, logic [31:0] flags);
		logic [31:0] inv, base, sel, first, dst;
		logic        done;
		inv  = ~mask;
		base = start & mask;
		sel  = '0;
		done = 1'b0;
		while (!done) begin
			first = (base | sel) >> PAGE_BITS;
			for (logic [31:0] p = 0; p < npages; p++) begin
				dst = (first + p) & INDEX_MASK;
				if (copy) begin
					page_image[dst] = page_image[(src_page + p) & INDEX_MASK];
				end else begin
					page_image[dst] = (p << PAGE_BITS) | flags;
				end
			end
			if (sel == inv) begin
				done = 1'b1;
			end else begin
				sel = ((sel | mask) + 32'd1) & inv;
			end
		end
	endfunction

	function automatic out_word_t predict_result(in_word_t w);
		out_word_t   r;
		logic [31:0] start, entry;
		r     = '0;
		start = w.address + w.base_offset;
		case (w.command)
			CMD_MOUNT: begin
				if (((start | w.size_bytes | ~w.address_mask) & OFFSET_MASK) != 0) begin
					r.align_error = 1'b1;
				end else if (w.region_handle < REGION_COUNT) begin
					write_mirrors(start, w.address_mask, w.size_bytes >> PAGE_BITS, '0, 1'b0,
						{24'd0, !w.region_dynamic, w.region_handle});
				end
			end
			CMD_MIRROR: begin
				if (((start | w.source_address | w.size_bytes) & OFFSET_MASK) != 0) begin
					r.align_error = 1'b1;
				end else begin
					write_mirrors(start, ALL_ONES, w.size_bytes >> PAGE_BITS,
						w.source_address >> PAGE_BITS, 1'b1, '0);
				end
			end
			CMD_LOOKUP: begin
				entry           = page_image[(w.address >> PAGE_BITS) & INDEX_MASK];
				r.entry_mapped  = (entry != 0);
				r.is_static     = entry[STATIC_BIT];
				r.region_index  = entry[HANDLE_W-1:0];
				r.mapped_offset = (entry & ~OFFSET_MASK) + (w.address & OFFSET_MASK);
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			foreach (page_image[i]) page_image[i] = '0;
			result_q.delete();
			fail_count   = 0;
			pending      = 0;
			lookup_count = 0;
			hit_count    = 0;
			reject_count = 0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				want = predict_result(cmd_word);
				result_q.push_back(want);
				if (cmd_word.command == CMD_LOOKUP) lookup_count++;
				if (want.entry_mapped) hit_count++;
				if (want.align_error) reject_count++;
			end
			if (res_valid && res_ready) begin
				if (result_q.size() == 0) begin
					$error("result word with no command outstanding: %h", res_word);
					fail_count++;
				end else begin
					want = result_q.pop_front();
					compare_field("entry_mapped", 32'(want.entry_mapped),
						32'(res_word.entry_mapped));
					compare_field("is_static", 32'(want.is_static), 32'(res_word.is_static));
					compare_field("region_index", 32'(want.region_index),
						32'(res_word.region_index));
					compare_field("mapped_offset", want.mapped_offset, res_word.mapped_offset);
					compare_field("align_error", 32'(want.align_error),
						32'(res_word.align_error));
				end
			end
			pending = result_q.size();
		end
	end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the page table mirror mapper with a directed set of mounts, mirror
// copies and lookups (alignment faults, wrap at the top of the address space,
// masked mirrors, overlapping copies, full-size ranges) and then a long
// random mix, with bursty command words and a stalling result side.
// ----------------------------------------------------------------------------
module tb_top;
	import ptmm_pkg::*;

	localparam int          PAGE_BITS    = 16;
	localparam int          RANDOM_WORDS = 1500;
	localparam logic [1:0]  CMD_UNUSED   = 2'd3;
	localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
	localparam logic [31:0] PAGE         = 32'd1 << PAGE_BITS;
	localparam logic [31:0] OFFSET_MASK  = PAGE - 32'd1;

	typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	in_word_t    cmd_word  = '0;
	logic        cmd_valid = 1'b0;
	logic        cmd_ready;
	out_word_t   res_word;
	logic        res_valid;
	logic        res_ready = 1'b0;
	int unsigned fail_count, pending, lookup_count, hit_count, reject_count;

	int unsigned burst_left = 0;
	logic [31:0] hot_pages [$];
	rx_mode_t    rx_mode = RX_OPEN;
	int unsigned rx_left = 0;
	logic [2:0]  rx_tick = '0;

	always #5 clk = ~clk;

	page_table_mirror_mapper #(
		.PAGE_BITS(PAGE_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_word (cmd_word),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.res_word (res_word),
		.res_valid(res_valid),
		.res_ready(res_ready)
	);

	ptmm_checker #(
		.PAGE_BITS(PAGE_BITS)
	) result_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_word    (cmd_word),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.res_word    (res_word),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.fail_count  (fail_count),
		.pending     (pending),
		.lookup_count(lookup_count),
		.hit_count   (hit_count),
		.reject_count(reject_count)
	);

	// result side: stall pattern is redrawn from open, light, heavy and periodic modes
	always @(posedge clk) begin
		rx_tick <= rx_tick + 3'd1;
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(20, 300);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:  res_ready <= 1'b1;
			RX_LIGHT: res_ready <= ($urandom_range(0, 3) != 0);
			RX_HEAVY: res_ready <= ($urandom_range(0, 3) == 0);
			default:  res_ready <= (rx_tick < 3'd3);
		endcase
	end

	function automatic in_word_t random_word(logic [1:0] cmd);
		in_word_t w;
		w.command        = cmd;
		w.address        = $urandom;
		w.address_mask   = $urandom;
		w.base_offset    = $urandom;
		w.size_bytes     = $urandom;
		w.source_address = $urandom;
		w.region_handle  = 7'($urandom_range(0, 127));
		w.region_dynamic = 1'($urandom_range(0, 1));
		return w;
	endfunction

	function automatic in_word_t mount_word(logic [31:0] target, logic [31:0] mask,
			logic [31:0] size, logic [6:0] handle, logic dynamic);
		in_word_t w;
		w                = random_word(CMD_MOUNT);
		w.address        = target - w.base_offset;
		w.address_mask   = mask;
		w.size_bytes     = size;
		w.region_handle  = handle;
		w.region_dynamic = dynamic;
		return w;
	endfunction

	function automatic in_word_t mirror_word(logic [31:0] target, logic [31:0] source,
			logic [31:0] size);
		in_word_t w;
		w                = random_word(CMD_MIRROR);
		w.address        = target - w.base_offset;
		w.source_address = source;
		w.size_bytes     = size;
		return w;
	endfunction

	function automatic in_word_t lookup_word(logic [31:0] addr);
		in_word_t w;
		w         = random_word(CMD_LOOKUP);
		w.address = addr;
		return w;
	endfunction

	// all ones except a few mirror bits above the page offset
	function automatic logic [31:0] pick_mask(int unsigned mirror_bits);
		logic [31:0] m;
		m = ALL_ONES;
		repeat (mirror_bits) m[$urandom_range(PAGE_BITS, 31)] = 1'b0;
		return m;
	endfunction

	function automatic logic [31:0] near_hot();
		if (hot_pages.size() == 0) return $urandom & ~OFFSET_MASK;
		return hot_pages[$urandom_range(0, hot_pages.size() - 1)] + PAGE * $urandom_range(0, 4);
	endfunction

	task automatic remember_page(logic [31:0] target);
		hot_pages.push_back(target);
		if (hot_pages.size() > 16) void'(hot_pages.pop_front());
	endtask

	task automatic push_word(in_word_t w);
		if (burst_left == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		cmd_word  <= w;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
	endtask

	initial begin
		in_word_t    w;
		int unsigned roll;
		logic [31:0] target, source;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// fresh table, odd command, start wrapping through base_offset
		push_word(lookup_word(32'h0000_0000));
		push_word(lookup_word(ALL_ONES));
		push_word(random_word(CMD_UNUSED));
		w             = mount_word(32'h0, ALL_ONES, 3 * PAGE, 7'd127, 1'b0);
		w.base_offset = 32'hFFFF_0000;
		w.address     = 32'h0001_0000;
		push_word(w);
		push_word(lookup_word(32'h0002_ABCD));
		// range running off the top continues at page zero
		push_word(mount_word(32'hFFFE_0000, ALL_ONES, 4 * PAGE, 7'd5, 1'b1));
		push_word(lookup_word(32'h0001_1234));
		// two mirror bits, four copies
		push_word(mount_word(32'h4030_0000, 32'hFFCF_FFFF, 2 * PAGE, 7'd9, 1'b0));
		push_word(lookup_word(32'h4021_0010));
		push_word(mirror_word(32'h8000_0000, 32'h4020_0000, 2 * PAGE));
		push_word(lookup_word(32'h8001_FFFF));
		// forward copy over its own source
		push_word(mirror_word(32'h0001_0000, 32'h0000_0000, 3 * PAGE));
		push_word(lookup_word(32'h0003_0000));
		push_word(mount_word(32'h5000_0000, ALL_ONES, 32'h0, 7'd3, 1'b0));
		// alignment faults
		push_word(mount_word(32'h5000_1234, ALL_ONES, PAGE, 7'd3, 1'b0));
		push_word(mount_word(32'h5000_0000, ALL_ONES, 32'h0001_8000, 7'd3, 1'b0));
		push_word(mount_word(32'h5000_0000, 32'h0000_0000, PAGE, 7'd3, 1'b0));
		push_word(mirror_word(32'h5000_0001, 32'h0, PAGE));
		push_word(mirror_word(32'h5000_0000, 32'h0000_8000, PAGE));
		push_word(mirror_word(32'h5000_0000, 32'h0, 32'hFFFF_FFFF));
		// handle zero on a dynamic region packs to an unmapped entry
		push_word(mount_word(32'h6000_0000, ALL_ONES, PAGE, 7'd0, 1'b1));
		push_word(lookup_word(32'h6000_0004));
		// full-size ranges, then every page rewritten to zero by mirrors
		push_word(mount_word(32'h0, ALL_ONES, 32'hFFFF_0000, 7'd1, 1'b1));
		push_word(mirror_word(32'h0, PAGE, 32'hFFFF_0000));
		push_word(lookup_word(32'h7777_7777));
		push_word(mount_word(32'h0, 32'h0000_FFFF, PAGE, 7'd0, 1'b1));
		push_word(lookup_word(32'h1234_5678));

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 50) begin
				push_word(lookup_word((roll < 40) ? near_hot() | (32'($urandom) & OFFSET_MASK)
					: 32'($urandom)));
			end else if (roll < 70) begin
				target = (roll < 60) ? near_hot() : ($urandom & ~OFFSET_MASK);
				push_word(mount_word(target, pick_mask($urandom_range(0, 3)),
					PAGE * $urandom_range(0, 4), 7'($urandom_range(0, 127)),
					1'($urandom_range(0, 1))));
				remember_page(target);
			end else if (roll < 85) begin
				source = near_hot();
				target = (roll < 75) ? source + PAGE * $urandom_range(1, 2)
					: ($urandom & ~OFFSET_MASK);
				push_word(mirror_word(target, source, PAGE * $urandom_range(0, 4)));
				remember_page(target);
			end else if (roll < 92) begin
				push_word(random_word(2'($urandom_range(0, 3))));
			end else begin
				if ($urandom_range(0, 1) == 0) begin
					w = mount_word(near_hot(), pick_mask(1), PAGE, 7'($urandom_range(0, 127)), 1'b0);
				end else begin
					w = mirror_word(near_hot(), near_hot(), PAGE);
				end
				case ($urandom_range(0, 2))
					0: w.address ^= 32'd1 << $urandom_range(0, PAGE_BITS - 1);
					1: w.size_bytes ^= 32'd1 << $urandom_range(0, PAGE_BITS - 1);
					default: begin
						if (w.command == CMD_MOUNT) begin
							w.address_mask ^= 32'd1 << $urandom_range(0, PAGE_BITS - 1);
						end else begin
							w.source_address ^= 32'd1 << $urandom_range(0, PAGE_BITS - 1);
						end
					end
				endcase
				push_word(w);
			end
		end
		cmd_valid <= 1'b0;

		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
		$display("Covered %0d lookups (%0d mapped) and %0d misaligned mount or mirror words,",
			lookup_count, hit_count, reject_count);
		$display("over directed extremes and %0d random words with bursty sends and stalls.",
			RANDOM_WORDS);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
